// ===== src/lcd_mode_line_timing_assert.svh =====
// Assertion macros for the LCD timing block.
`ifndef LCD_MODE_LINE_TIMING_ASSERT_SVH
`define LCD_MODE_LINE_TIMING_ASSERT_SVH

`ifndef SYNTHESIS

// ante true at an edge -> cons holds at the same edge
`define LCDT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lcd timing assertion failed");

// ante true at an edge -> cons holds at the next edge
`define LCDT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lcd timing assertion failed");

`else

`define LCDT_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define LCDT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== src/lcdt_pkg.sv =====
`default_nettype none

package lcdt_pkg;

    localparam int unsigned DOT_W  = 10;
    localparam int unsigned LINE_W = 8;
    localparam int unsigned CYC_W  = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;

    localparam logic [DOT_W-1:0]  DOTS_OAM_END      = DOT_W'(80);
    localparam logic [DOT_W-1:0]  DOTS_XFER_END     = DOT_W'(252);
    localparam logic [DOT_W-1:0]  DOTS_PER_LINE     = DOT_W'(456);
    localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = LINE_W'(144);
    localparam logic [LINE_W-1:0] LAST_LINE         = LINE_W'(153);

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISPLAY_ENABLE     = 3'd0,
        CFG_HBLANK_IRQ_ENABLE  = 3'd1,
        CFG_VBLANK_IRQ_ENABLE  = 3'd2,
        CFG_OAM_IRQ_ENABLE     = 3'd3,
        CFG_COMPARE_IRQ_ENABLE = 3'd4,
        CFG_COMPARE_LINE       = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic              display_enable;
        logic              hblank_irq_enable;
        logic              vblank_irq_enable;
        logic              oam_irq_enable;
        logic              compare_irq_enable;
        logic [LINE_W-1:0] compare_line;
    } cfg_t;

    typedef struct packed {
        logic [DOT_W-1:0]  dot_counter;
        logic [LINE_W-1:0] scan_line;
        mode_t             mode;
        logic              match_flag;
    } timing_state_t;

    typedef struct packed {
        logic              status_irq;
        logic              vblank_irq;
        logic              draw_line_valid;
        logic [LINE_W-1:0] draw_line_index;
        logic              frame_done;
    } events_t;

endpackage

`default_nettype wire

// ===== src/lcdt_step.sv =====
`default_nettype none

// Next timing state and events for one item of elapsed cycles.
module lcdt_step (
    input  wire lcdt_pkg::cfg_t          cfg,
    input  wire lcdt_pkg::timing_state_t cur,
    input  wire logic [lcdt_pkg::CYC_W-1:0] elapsed_cycles,
    output lcdt_pkg::timing_state_t      nxt,
    output lcdt_pkg::events_t            evt
);
    import lcdt_pkg::*;

    logic [DOT_W-1:0] dot_sum;
    logic             in_vblank;
    logic             line_end;
    logic             line_eq;
    logic             mode_irq;
    mode_t            want;
    logic             want_en;

    always_comb begin
        dot_sum   = cur.dot_counter + DOT_W'(elapsed_cycles);
        in_vblank = (cur.scan_line >= FIRST_VBLANK_LINE);
        line_end  = (dot_sum >= DOTS_PER_LINE);
        line_eq   = (cur.scan_line == cfg.compare_line);

        if (in_vblank) begin
            want    = MODE_VBLANK;
            want_en = cfg.vblank_irq_enable;
        end else if (dot_sum <= DOTS_OAM_END) begin
            want    = MODE_OAM;
            want_en = cfg.oam_irq_enable;
        end else if (dot_sum <= DOTS_XFER_END) begin
            want    = MODE_XFER;
            want_en = 1'b0;
        end else begin
            want    = MODE_HBLANK;
            want_en = cfg.hblank_irq_enable;
        end
        mode_irq = (cur.mode != want) && want_en;

        nxt = cur;
        evt = '0;
        if (!cfg.display_enable) begin
            // timing held in reset; match flag keeps its value
            nxt.dot_counter = '0;
            nxt.scan_line   = '0;
            nxt.mode        = MODE_HBLANK;
        end else begin
            nxt.mode        = want;
            nxt.match_flag  = line_eq;
            evt.status_irq  = mode_irq || (line_eq && cfg.compare_irq_enable);
            nxt.dot_counter = line_end ? (dot_sum - DOTS_PER_LINE) : dot_sum;
            if (line_end) begin
                if (!in_vblank) begin
                    evt.draw_line_valid = 1'b1;
                    evt.draw_line_index = cur.scan_line;
                end else if (cur.scan_line == FIRST_VBLANK_LINE) begin
                    evt.vblank_irq = 1'b1;
                    evt.frame_done = 1'b1;
                end
                nxt.scan_line = (cur.scan_line > LAST_LINE) ? '0
                                                            : cur.scan_line + LINE_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/lcd_mode_line_timing.sv =====
`default_nettype none

// LCD mode and scan-line timing. Each input item carries the machine cycles
// elapsed since the previous item; the block adds them to a dot counter and
// returns one result item per input item: display mode, scan line, line
// compare flag and the interrupt / line-draw / frame events of that step
// (frame_done is carried on m_tlast). One item per clock is accepted when
// the output register is empty or being read; the result enters it in the
// cycle after acceptance. The user must write timing registers through the
// cfg port only while no item is in flight; the block does not enforce it.
`include "lcd_mode_line_timing_assert.svh"

module lcd_mode_line_timing (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [lcdt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lcdt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [7:0] elapsed_cycles
    input  wire logic [lcdt_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] display_mode, [9:2] current_line, [10] line_match, [11] status_irq,
    // [12] vblank_irq, [13] draw_line_valid, [21:14] draw_line_index, [23:22] zero
    output logic [lcdt_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                   m_tlast
);
    import lcdt_pkg::*;

    cfg_t          cfg_reg;
    timing_state_t state_reg, state_next;
    events_t       evt_next;
    logic          in_accept;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tlast_reg;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DISPLAY_ENABLE:     cfg_reg.display_enable     <= cfg_data[0];
                CFG_HBLANK_IRQ_ENABLE:  cfg_reg.hblank_irq_enable  <= cfg_data[0];
                CFG_VBLANK_IRQ_ENABLE:  cfg_reg.vblank_irq_enable  <= cfg_data[0];
                CFG_OAM_IRQ_ENABLE:     cfg_reg.oam_irq_enable     <= cfg_data[0];
                CFG_COMPARE_IRQ_ENABLE: cfg_reg.compare_irq_enable <= cfg_data[0];
                CFG_COMPARE_LINE:       cfg_reg.compare_line       <= cfg_data;
                default: ;
            endcase
        end
    end

    lcdt_step u_step (
        .cfg            (cfg_reg),
        .cur            (state_reg),
        .elapsed_cycles (s_tdata[CYC_W-1:0]),
        .nxt            (state_next),
        .evt            (evt_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{dot_counter: '0, scan_line: '0, mode: MODE_HBLANK,
                           match_flag: 1'b0};
        end else if (in_accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_tdata_reg <= {2'b00,
                            evt_next.draw_line_index,
                            evt_next.draw_line_valid,
                            evt_next.vblank_irq,
                            evt_next.status_irq,
                            state_next.match_flag,
                            state_next.scan_line,
                            state_next.mode};
            m_tlast_reg <= evt_next.frame_done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `LCDT_ASSERT_SAME(a_dot_in_line, aclk, aresetn, 1'b1, state_reg.dot_counter < DOTS_PER_LINE)
    `LCDT_ASSERT_SAME(a_line_range, aclk, aresetn, 1'b1, state_reg.scan_line <= LAST_LINE + LINE_W'(1))
    `LCDT_ASSERT_NEXT(a_display_off, aclk, aresetn, in_accept && !cfg_reg.display_enable, state_reg.dot_counter == '0 && state_reg.scan_line == '0 && m_tdata_reg[13:11] == 3'd0 && !m_tlast_reg)
    `LCDT_ASSERT_SAME(a_draw_visible, aclk, aresetn, m_tvalid && m_tdata[13], m_tdata[21:14] < FIRST_VBLANK_LINE && !m_tlast)

endmodule

`default_nettype wire
